/* design/bcrt_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcrt_pkg
// shared types, register codes, keys and the refresh prescaler table
// ----------------------------------------------------------------------------
package bcrt_pkg;

  // width of the free-running base cycle counter (12 to 16)
  localparam int BASE_COUNTER_BITS = 12;

  // commands
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_NONE  = 2'd3;

  // register indexes
  localparam logic [3:0] REG_BCR   = 4'd0;
  localparam logic [3:0] REG_WCR1  = 4'd1;
  localparam logic [3:0] REG_WCR2  = 4'd2;
  localparam logic [3:0] REG_WCR3  = 4'd3;
  localparam logic [3:0] REG_DCR   = 4'd4;
  localparam logic [3:0] REG_PCR   = 4'd5;
  localparam logic [3:0] REG_RCR   = 4'd6;
  localparam logic [3:0] REG_RTCSR = 4'd7;
  localparam logic [3:0] REG_RTCNT = 4'd8;
  localparam logic [3:0] REG_RTCOR = 4'd9;

  // write keys for the protected registers
  localparam logic [7:0] KEY_RCR   = 8'h5A;
  localparam logic [7:0] KEY_RTCSR = 8'hA5;
  localparam logic [7:0] KEY_RTCNT = 8'h69;
  localparam logic [7:0] KEY_RTCOR = 8'h96;

  // write masks
  localparam logic [15:0] MASK_HI5    = 16'hF800;
  localparam logic [15:0] MASK_HI8    = 16'hFF00;
  localparam logic [15:0] WCR1_FORCE  = 16'h00FD;
  localparam logic [7:0]  RCR_MASK    = 8'hF8;

  // reset values
  localparam logic [15:0] WCR_RESET   = 16'hFFFF;
  localparam logic [15:0] WCR3_RESET  = 16'hF800;
  localparam logic [7:0]  RTCOR_RESET = 8'hFF;

  // rtcsr bit positions
  localparam int CMF_POS  = 7;
  localparam int CMIE_POS = 6;

  // prescaler shift per clock select code
  localparam logic [3:0] PRESCALE_SHIFT [8] = '{
    4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd12
  };

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  reg_index;
    logic        byte_access;
    logic        byte_odd;
    logic [15:0] write_data;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_request;
  } result_t;

  // low bits of the base counter that must be zero for a refresh count
  function automatic logic [BASE_COUNTER_BITS-1:0] prescale_mask(input logic [2:0] cks);
    logic [BASE_COUNTER_BITS-1:0] m;
    logic [3:0] sh;
    sh = PRESCALE_SHIFT[cks];
    for (int i = 0; i < BASE_COUNTER_BITS; i++) begin
      m[i] = (i < int'(sh));
    end
    return m;
  endfunction

endpackage

/* design/bcrt_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcrt channel interfaces
// valid/ready channels for items in and results out
// ----------------------------------------------------------------------------
interface bcrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [3:0]  reg_index;
  logic        byte_access;
  logic        byte_odd;
  logic [15:0] write_data;

  modport source (output valid, command, reg_index, byte_access, byte_odd, write_data,
                  input ready);
  modport sink (input valid, command, reg_index, byte_access, byte_odd, write_data,
                output ready);
endinterface

interface bcrt_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] read_data;
  logic        irq_request;

  modport source (output valid, read_data, irq_request, input ready);
  modport sink (input valid, read_data, irq_request, output ready);
endinterface

/* design/bcrt_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcrt_regfile
// bus control registers and refresh timer, one item per step
// ----------------------------------------------------------------------------
module bcrt_regfile (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_go,
  input  bcrt_pkg::item_t   item,
  output bcrt_pkg::result_t result
);

  logic [15:0] bcr_r, bcr_nxt;
  logic [15:0] wcr1_r, wcr1_nxt;
  logic [15:0] wcr2_r, wcr2_nxt;
  logic [15:0] wcr3_r, wcr3_nxt;
  logic [15:0] dcr_r, dcr_nxt;
  logic [15:0] pcr_r, pcr_nxt;
  logic [7:0]  rcr_r, rcr_nxt;
  logic [7:0]  rtcsr_r, rtcsr_nxt;
  logic [7:0]  rtcnt_r, rtcnt_nxt;
  logic [7:0]  rtcor_r, rtcor_nxt;
  logic        seen_r, seen_nxt;
  logic [bcrt_pkg::BASE_COUNTER_BITS-1:0] base_r, base_nxt;

  logic [15:0] cur_word;
  logic [15:0] wval;
  logic [15:0] rdata;
  logic [7:0]  wkey;
  logic [7:0]  wdat;
  logic        plain_reg;
  logic        do_write;

  // current word of the addressed register
  always_comb begin
    unique case (item.reg_index)
      bcrt_pkg::REG_BCR:   cur_word = bcr_r;
      bcrt_pkg::REG_WCR1:  cur_word = wcr1_r;
      bcrt_pkg::REG_WCR2:  cur_word = wcr2_r;
      bcrt_pkg::REG_WCR3:  cur_word = wcr3_r;
      bcrt_pkg::REG_DCR:   cur_word = dcr_r;
      bcrt_pkg::REG_PCR:   cur_word = pcr_r;
      bcrt_pkg::REG_RCR:   cur_word = {8'h00, rcr_r};
      bcrt_pkg::REG_RTCSR: cur_word = {8'h00, rtcsr_r};
      bcrt_pkg::REG_RTCNT: cur_word = {8'h00, rtcnt_r};
      bcrt_pkg::REG_RTCOR: cur_word = {8'h00, rtcor_r};
      default:             cur_word = 16'h0000;
    endcase
  end

  assign plain_reg = (item.reg_index == bcrt_pkg::REG_BCR) ||
                     (item.reg_index == bcrt_pkg::REG_WCR1) ||
                     (item.reg_index == bcrt_pkg::REG_WCR2) ||
                     (item.reg_index == bcrt_pkg::REG_WCR3) ||
                     (item.reg_index == bcrt_pkg::REG_DCR) ||
                     (item.reg_index == bcrt_pkg::REG_PCR);

  // byte writes merge into the current word, word writes pass whole
  always_comb begin
    if (!item.byte_access) begin
      wval = item.write_data;
    end else if (item.byte_odd) begin
      wval = {cur_word[15:8], item.write_data[7:0]};
    end else begin
      wval = {item.write_data[7:0], cur_word[7:0]};
    end
  end

  assign wkey     = wval[15:8];
  assign wdat     = wval[7:0];
  assign do_write = !item.byte_access || plain_reg;

  always_comb begin
    bcr_nxt   = bcr_r;
    wcr1_nxt  = wcr1_r;
    wcr2_nxt  = wcr2_r;
    wcr3_nxt  = wcr3_r;
    dcr_nxt   = dcr_r;
    pcr_nxt   = pcr_r;
    rcr_nxt   = rcr_r;
    rtcsr_nxt = rtcsr_r;
    rtcnt_nxt = rtcnt_r;
    rtcor_nxt = rtcor_r;
    seen_nxt  = seen_r;
    base_nxt  = base_r;
    rdata     = 16'h0000;
    unique case (item.command)
      bcrt_pkg::CMD_TICK: begin
        base_nxt = base_r + 1'b1;
        if ((rtcsr_r[5:3] != 3'd0) &&
            ((base_nxt & bcrt_pkg::prescale_mask(rtcsr_r[5:3])) == '0)) begin
          if (rtcnt_r == rtcor_r) begin
            rtcnt_nxt = 8'h00;
            rtcsr_nxt[bcrt_pkg::CMF_POS] = 1'b1;
          end else begin
            rtcnt_nxt = rtcnt_r + 8'd1;
          end
        end
      end
      bcrt_pkg::CMD_READ: begin
        if ((item.reg_index == bcrt_pkg::REG_RTCSR) && rtcsr_r[bcrt_pkg::CMF_POS]) begin
          seen_nxt = 1'b1;
        end
        if (!item.byte_access) begin
          rdata = cur_word;
        end else if (item.byte_odd) begin
          rdata = {8'h00, cur_word[7:0]};
        end else begin
          rdata = {8'h00, cur_word[15:8]};
        end
      end
      bcrt_pkg::CMD_WRITE: begin
        if (do_write) begin
          unique case (item.reg_index)
            bcrt_pkg::REG_BCR:  bcr_nxt  = wval & bcrt_pkg::MASK_HI5;
            bcrt_pkg::REG_WCR1: wcr1_nxt = wval | bcrt_pkg::WCR1_FORCE;
            bcrt_pkg::REG_WCR2: wcr2_nxt = wval;
            bcrt_pkg::REG_WCR3: wcr3_nxt = wval & bcrt_pkg::MASK_HI5;
            bcrt_pkg::REG_DCR:  dcr_nxt  = wval & bcrt_pkg::MASK_HI8;
            bcrt_pkg::REG_PCR:  pcr_nxt  = wval & bcrt_pkg::MASK_HI5;
            bcrt_pkg::REG_RCR: begin
              if (wkey == bcrt_pkg::KEY_RCR) rcr_nxt = wdat & bcrt_pkg::RCR_MASK;
            end
            bcrt_pkg::REG_RTCSR: begin
              if (wkey == bcrt_pkg::KEY_RTCSR) begin
                // flag clears only on a written 0 after it was read as 1
                rtcsr_nxt = {rtcsr_r[bcrt_pkg::CMF_POS] &
                             !(!wdat[bcrt_pkg::CMF_POS] && seen_r),
                             wdat[6:3], 3'b000};
                seen_nxt  = 1'b0;
              end
            end
            bcrt_pkg::REG_RTCNT: begin
              if (wkey == bcrt_pkg::KEY_RTCNT) rtcnt_nxt = wdat;
            end
            bcrt_pkg::REG_RTCOR: begin
              if (wkey == bcrt_pkg::KEY_RTCOR) rtcor_nxt = wdat;
            end
            default: ;
          endcase
        end
      end
      bcrt_pkg::CMD_NONE: ;
      default: ;
    endcase
  end

  assign result.read_data   = rdata;
  assign result.irq_request = rtcsr_nxt[bcrt_pkg::CMF_POS] & rtcsr_nxt[bcrt_pkg::CMIE_POS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcr_r   <= 16'h0000;
      wcr1_r  <= bcrt_pkg::WCR_RESET;
      wcr2_r  <= bcrt_pkg::WCR_RESET;
      wcr3_r  <= bcrt_pkg::WCR3_RESET;
      dcr_r   <= 16'h0000;
      pcr_r   <= 16'h0000;
      rcr_r   <= 8'h00;
      rtcsr_r <= 8'h00;
      rtcnt_r <= 8'h00;
      rtcor_r <= bcrt_pkg::RTCOR_RESET;
      seen_r  <= 1'b0;
      base_r  <= '0;
    end else if (step_go) begin
      bcr_r   <= bcr_nxt;
      wcr1_r  <= wcr1_nxt;
      wcr2_r  <= wcr2_nxt;
      wcr3_r  <= wcr3_nxt;
      dcr_r   <= dcr_nxt;
      pcr_r   <= pcr_nxt;
      rcr_r   <= rcr_nxt;
      rtcsr_r <= rtcsr_nxt;
      rtcnt_r <= rtcnt_nxt;
      rtcor_r <= rtcor_nxt;
      seen_r  <= seen_nxt;
      base_r  <= base_nxt;
    end
  end

endmodule

/* design/bus_controller_refresh_timer_unit.sv */
`timescale 1ns / 1ps
// throughput: one item per cycle, sustained while the result side keeps up
// the input register feeds one pass through the register file logic into the result register
// reset: synchronous active-low; registers take their documented reset values,
// both pipeline stages empty, prescaler base counter at zero
// ----------------------------------------------------------------------------
// bus_controller_refresh_timer_unit
// bus controller register file with keyed refresh timer and compare match irq
// ----------------------------------------------------------------------------
module bus_controller_refresh_timer_unit (
  input  logic              clk,
  input  logic              rst_n,
  bcrt_in_if.sink           in_ch,
  bcrt_out_if.source        out_ch
);

  // input register stage
  logic              s1_valid_r;
  bcrt_pkg::item_t   s1_item_r;

  // result register stage
  logic              out_valid_r;
  bcrt_pkg::result_t out_res_r;

  bcrt_pkg::result_t step_res;
  logic              out_free;
  logic              step_go;
  logic              in_xfer;

  // result register can load when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;
  // item in the input register is processed when the result register can take it
  assign step_go  = s1_valid_r && out_free;
  // input register accepts while empty or while its item moves on
  assign in_ch.ready = !s1_valid_r || step_go;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.command     <= in_ch.command;
      s1_item_r.reg_index   <= in_ch.reg_index;
      s1_item_r.byte_access <= in_ch.byte_access;
      s1_item_r.byte_odd    <= in_ch.byte_odd;
      s1_item_r.write_data  <= in_ch.write_data;
    end
  end

  // register file and timer, state commits on step_go
  bcrt_regfile u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_go (step_go),
    .item    (s1_item_r),
    .result  (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= step_go;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_res_r <= step_res;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.read_data   = out_res_r.read_data;
  assign out_ch.irq_request = out_res_r.irq_request;

  // a processed item always lands in the result register
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step_go |=> out_valid_r)
    else $error("processed item did not reach the result register");

  // a waiting item is neither lost nor overwritten
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !step_go) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("input register item changed while waiting");

  // a stalled result is never replaced by a new one
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !step_go)
    else $error("result register overwritten while stalled");

endmodule
